>>> src/i2f_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_pkg
// Shared widths, constants and stage payload types for int128_to_float64.
// ----------------------------------------------------------------------------
package i2f_pkg;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned MANT_BITS = 52;
    localparam int unsigned EXP_W     = 11;
    localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;

    typedef struct packed {
        logic              neg;
        logic [WORD_W-1:0] mant;
        logic [LEN_W-1:0]  k;
    } t_mant;

    typedef struct packed {
        logic              neg;
        logic              zero;
        logic [WORD_W-1:0] norm;
        logic [LEN_W-1:0]  n;
        logic [LEN_W-1:0]  k;
    } t_norm;

    function automatic logic [LEN_W-1:0] bit_len(input logic [WORD_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                r = LEN_W'(i + 1);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> src/i2f_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2f_stage
// One pipeline register stage with valid and stall handshake.
// ----------------------------------------------------------------------------
module i2f_stage #(
    parameter int unsigned W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [W-1:0]      o_data
);
    logic         r_valid;
    logic [W-1:0] r_data;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_data));
    endproperty
    a_hold: assert property (p_hold) else $error("stalled stage lost data");

    property p_load;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_valid;
    endproperty
    a_load: assert property (p_load) else $error("accepted transaction dropped");

    property p_empty;
        @(posedge i_clk) disable iff (!i_rst_n)
        (!i_valid && !o_stall) |=> !r_valid;
    endproperty
    a_empty: assert property (p_empty) else $error("transaction invented");
endmodule
`default_nettype wire

>>> src/int128_to_float64.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int128_to_float64
// Converts a signed 128-bit integer to IEEE 754 binary64 bits.
//
// The input channel carries value_hi and value_lo; a transaction is accepted
// when i_valid is high and o_stall is low. The output channel carries
// double_bits; a transaction leaves when o_valid is high and i_stall is low.
// The block is a four-stage pipeline: magnitude and mantissa selection,
// bit length, normalizing shift, and rounding with packing. Each stage is a
// register, and one transaction can be accepted in every cycle in which
// o_stall is low. A stall from the receiver holds each occupied stage that
// has no empty stage below it; empty stages still fill, so bubbles close up
// and nothing is lost or repeated. The synchronous reset empties all stages.
// ----------------------------------------------------------------------------
module int128_to_float64 (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic signed [i2f_pkg::WORD_W-1:0] i_value_hi,
    input  wire logic [i2f_pkg::WORD_W-1:0]  i_value_lo,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [i2f_pkg::WORD_W-1:0]       o_double_bits
);
    import i2f_pkg::*;

    localparam int unsigned MW = $bits(t_mant);
    localparam int unsigned NW = $bits(t_norm);

    logic [2*WORD_W-1:0] mag;
    logic [WORD_W-1:0]   mhi;
    logic [LEN_W-1:0]    khi;
    t_mant               s1_in;
    t_mant               s1_out;
    t_mant               s2_out;
    logic [LEN_W-1:0]    s2_n;
    logic [MW+LEN_W-1:0] s2_data;
    logic [MW+LEN_W-1:0] s2_q;
    logic                s1_valid, s2_valid, s3_valid;
    logic                st1, st2, st3;
    t_norm               s3_in;
    t_norm               s3_out;
    logic [LEN_W-1:0]    shl;
    logic [52:0]         q;
    logic [53:0]         qr;
    logic                guard, sticky;
    logic [EXP_W-1:0]    expo;
    logic [WORD_W-1:0]   bits;

    always_comb begin
        mag = {i_value_hi, i_value_lo};
        if (i_value_hi[WORD_W-1]) begin
            mag = ~mag + 1'b1;
        end
        mhi = mag[2*WORD_W-1:WORD_W];
        khi = bit_len(mhi);
        s1_in.neg = i_value_hi[WORD_W-1];
        s1_in.k   = khi;
        if (mhi == '0) begin
            s1_in.mant = mag[WORD_W-1:0];
        end else begin
            s1_in.mant = WORD_W'(mag >> khi);
        end
    end

    i2f_stage #(.W(MW)) u_s1 (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_data(s1_in), .o_valid(s1_valid), .i_stall(st1), .o_data(s1_out)
    );

    assign s2_n    = bit_len(s1_out.mant);
    assign s2_data = {s1_out, s2_n};

    i2f_stage #(.W(MW+LEN_W)) u_s2 (
        .i_clk, .i_rst_n, .i_valid(s1_valid), .o_stall(st1),
        .i_data(s2_data), .o_valid(s2_valid), .i_stall(st2), .o_data(s2_q)
    );

    always_comb begin
        s2_out     = s2_q[MW+LEN_W-1:LEN_W];
        shl        = LEN_W'(WORD_W) - s2_q[LEN_W-1:0];
        s3_in.neg  = s2_out.neg;
        s3_in.k    = s2_out.k;
        s3_in.n    = s2_q[LEN_W-1:0];
        s3_in.zero = (s2_out.mant == '0);
        s3_in.norm = s2_out.mant << shl;
    end

    i2f_stage #(.W(NW)) u_s3 (
        .i_clk, .i_rst_n, .i_valid(s2_valid), .o_stall(st2),
        .i_data(s3_in), .o_valid(s3_valid), .i_stall(st3), .o_data(s3_out)
    );

    always_comb begin
        q      = s3_out.norm[63:11];
        guard  = s3_out.norm[10];
        sticky = |s3_out.norm[9:0];
        qr     = {1'b0, q} + 54'((guard && (sticky || q[0])) ? 1 : 0);
        expo   = EXP_BIAS + EXP_W'(s3_out.n) - EXP_W'(1) + EXP_W'(s3_out.k)
               + EXP_W'(qr[53]);
        if (s3_out.zero) begin
            bits = '0;
        end else if (qr[53]) begin
            bits = {s3_out.neg, expo, qr[52:1]};
        end else begin
            bits = {s3_out.neg, expo, qr[51:0]};
        end
    end

    i2f_stage #(.W(WORD_W)) u_s4 (
        .i_clk, .i_rst_n, .i_valid(s3_valid), .o_stall(st3),
        .i_data(bits), .o_valid, .i_stall, .o_data(o_double_bits)
    );
endmodule
`default_nettype wire
